// ----- hw/rtl/mfopt_pkg.sv -----
`default_nettype none
package mfopt_pkg;

    // table geometry
    localparam int MAX_FRAMES   = 8;
    localparam int IDX_W        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    // CORDIC setup
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int IT_W         = $clog2(TAB_LEN);
    localparam int CW           = 38;          // CORDIC x/y datapath
    localparam int ZW           = 34;          // CORDIC angle accumulator
    localparam int BW           = 34;          // multiplier B operand
    localparam int PW           = CW + BW;     // product / accumulator

    localparam logic signed [CW-1:0] KINV_Q30   = CW'(652032875);
    localparam logic signed [BW-1:0] KINV_Q28   = BW'(163008219);
    localparam logic signed [ZW-1:0] HALF_PI_Z  = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] PI_Z       = ZW'(64'sd2147483648);

    typedef enum logic [2:0] {
        MODE_UPD_REL  = 3'd0,
        MODE_UPD_ABS  = 3'd1,
        MODE_ADD_ABS  = 3'd2,
        MODE_ADD_REL  = 3'd3,
        MODE_DELETE   = 3'd4,
        MODE_GET_POS  = 3'd5,
        MODE_XFORM    = 3'd6,
        MODE_DIST     = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO_ID   = 2'd3
    } status_t;

    // request from sequencer to the CORDIC unit
    typedef struct packed {
        logic start;
        logic vec;     // 1: vectoring (magnitude), 0: rotation (sin/cos)
    } cord_req_t;

    // arctan(2^-i) as 32-bit binary angle
    function automatic logic [31:0] atan_b32(input logic [IT_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // (v + 2^29) >>> 30, saturated to signed 32 bits
    function automatic logic signed [31:0] rnd30_sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        logic signed [31:0]   r;
        t = (v + PW'(64'sd536870912)) >>> 30;
        if (t > PW'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (t < -PW'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = t[31:0];
        end
        return r;
    endfunction

    // (v + 2^27) >>> 28, clamped to [0, 2^31-1]
    function automatic logic [30:0] rnd28_dist(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        logic [30:0]          r;
        t = (v + PW'(64'sd134217728)) >>> 28;
        if (t < 0) begin
            r = '0;
        end else if (t > PW'(64'sd2147483647)) begin
            r = 31'h7FFFFFFF;
        end else begin
            r = t[30:0];
        end
        return r;
    endfunction

    // signed 33-bit sum saturated to 32 bits
    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mfopt_cordic.sv -----
`default_nettype none
module mfopt_cordic (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire mfopt_pkg::cord_req_t                req,
    input  wire logic signed [15:0]                  ang,
    input  wire logic signed [mfopt_pkg::CW-1:0]     vx,
    input  wire logic signed [mfopt_pkg::CW-1:0]     vy,
    output logic                                     done,
    output logic signed [mfopt_pkg::CW-1:0]          x_out,
    output logic signed [mfopt_pkg::CW-1:0]          y_out
);

    logic signed [mfopt_pkg::CW-1:0]   x_reg, x_next;
    logic signed [mfopt_pkg::CW-1:0]   y_reg, y_next;
    logic signed [mfopt_pkg::ZW-1:0]   z_reg, z_next;
    logic [mfopt_pkg::IT_W-1:0]        it_reg, it_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic                              vec_reg, vec_next;
    logic                              flip_reg, flip_next;

    logic signed [mfopt_pkg::ZW-1:0]   z_init;
    logic signed [mfopt_pkg::CW-1:0]   sx, sy;
    logic signed [mfopt_pkg::ZW-1:0]   at;
    logic                              pos;

    // 16-bit binary angle scaled to a 32-bit binary angle, sign-extended to ZW bits
    assign z_init = {{(mfopt_pkg::ZW-32){ang[15]}}, ang, 16'h0000};

    // one micro-rotation per cycle
    assign sx  = x_reg >>> it_reg;
    assign sy  = y_reg >>> it_reg;
    assign at  = mfopt_pkg::ZW'(mfopt_pkg::atan_b32(it_reg));
    assign pos = vec_reg ? (y_reg <= 0) : (z_reg >= 0);

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        vec_next  = vec_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            it_next   = '0;
            vec_next  = req.vec;
            if (req.vec) begin
                x_next    = (vx < 0) ? -vx : vx;
                y_next    = vy;
                z_next    = '0;
                flip_next = 1'b0;
            end else begin
                x_next = mfopt_pkg::KINV_Q30;
                y_next = '0;
                // fold into [-pi/2, pi/2]
                if (z_init > mfopt_pkg::HALF_PI_Z) begin
                    z_next    = z_init - mfopt_pkg::PI_Z;
                    flip_next = 1'b1;
                end else if (z_init < -mfopt_pkg::HALF_PI_Z) begin
                    z_next    = z_init + mfopt_pkg::PI_Z;
                    flip_next = 1'b1;
                end else begin
                    z_next    = z_init;
                    flip_next = 1'b0;
                end
            end
        end else if (busy_reg) begin
            if (pos) begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + at;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == mfopt_pkg::IT_W'(mfopt_pkg::CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        it_reg   <= it_next;
        vec_reg  <= vec_next;
        flip_reg <= flip_next;
    end

    assign done  = done_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign y_out = flip_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/multi_frame_odometry_pose_table.sv -----
// Work: the scan visits slots in order; each CORDIC job (one shared CORDIC) is followed
//   by a multiply/accumulate in S_MUL, then rounding in S_RND and, for updates, S_APPLY.
// Update walks all MAX_FRAMES slots and runs a CORDIC job for each occupied frame.
// Throughput: one beat at a time; a new beat is taken while the last result waits.
// Reset (synchronous, aresetn low): all slots free, next id = 1, no result pending.
`default_nettype none
module multi_frame_odometry_pose_table (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_mode,
    input  wire logic signed [31:0]   s_dx_or_x,
    input  wire logic signed [31:0]   s_dy_or_y,
    input  wire logic signed [15:0]   s_angle,
    input  wire logic [63:0]          s_frame_id,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [63:0]               m_new_id,
    output logic signed [31:0]        m_out_x,
    output logic signed [31:0]        m_out_y,
    output logic signed [15:0]        m_out_theta,
    output logic [30:0]               m_distance
);

    localparam int NF = mfopt_pkg::MAX_FRAMES;
    localparam int IW = mfopt_pkg::IDX_W;
    localparam int CW = mfopt_pkg::CW;
    localparam int BW = mfopt_pkg::BW;
    localparam int PW = mfopt_pkg::PW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_CORD  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_RND   = 7'b0010000,
        S_APPLY = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // frame table
    logic [63:0]        ids_reg [NF], ids_next [NF];
    logic signed [31:0] fx_reg  [NF], fx_next  [NF];
    logic signed [31:0] fy_reg  [NF], fy_next  [NF];
    logic signed [15:0] hd_reg  [NF], hd_next  [NF];
    logic [63:0]        nid_reg, nid_next;

    // latched beat
    mfopt_pkg::mode_t   mode_reg, mode_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic signed [15:0] ang_reg, ang_next;
    logic [63:0]        qid_reg, qid_next;

    // work registers
    logic [IW-1:0]      idx_reg, idx_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [32:0] u_reg, u_next;
    logic signed [32:0] v_reg, v_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] s1_reg, s1_next;
    logic signed [PW-1:0] s2_reg, s2_next;
    logic signed [31:0] gx_reg, gx_next;
    logic signed [31:0] gy_reg, gy_next;

    // pending result
    mfopt_pkg::status_t rst_reg, rst_next;
    logic [63:0]        rnid_reg, rnid_next;
    logic signed [31:0] rx_reg, rx_next;
    logic signed [31:0] ry_reg, ry_next;
    logic signed [15:0] rth_reg, rth_next;
    logic [30:0]        rd_reg, rd_next;

    // output register
    logic               mv_reg, mv_next;
    logic [1:0]         ost_reg, ost_next;
    logic [63:0]        onid_reg, onid_next;
    logic signed [31:0] ox_reg, ox_next;
    logic signed [31:0] oy_reg, oy_next;
    logic signed [15:0] oth_reg, oth_next;
    logic [30:0]        od_reg, od_next;

    // CORDIC hookup
    mfopt_pkg::cord_req_t  creq;
    logic signed [15:0]    cang;
    logic signed [CW-1:0]  cvx, cvy;
    logic                  cdone;
    logic signed [CW-1:0]  cx, cy;

    mfopt_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .ang     (cang),
        .vx      (cvx),
        .vy      (cvy),
        .done    (cdone),
        .x_out   (cx),
        .y_out   (cy)
    );

    // slot view and scan decode
    logic [63:0]        cur_id;
    logic signed [31:0] cur_x, cur_y;
    logic signed [15:0] cur_hd;
    logic               is_upd, is_add, hit, last;
    logic signed [32:0] du, dv;
    logic [63:0]        nid_inc;

    assign cur_id = ids_reg[idx_reg];
    assign cur_x  = fx_reg[idx_reg];
    assign cur_y  = fy_reg[idx_reg];
    assign cur_hd = hd_reg[idx_reg];
    assign is_upd = (mode_reg == mfopt_pkg::MODE_UPD_REL) || (mode_reg == mfopt_pkg::MODE_UPD_ABS);
    assign is_add = (mode_reg == mfopt_pkg::MODE_ADD_ABS) || (mode_reg == mfopt_pkg::MODE_ADD_REL);
    assign hit    = is_upd ? (cur_id != 64'd0) :
                    is_add ? (cur_id == 64'd0) : (cur_id == qid_reg);
    assign last   = (idx_reg == IW'(NF - 1));
    assign du     = {px_reg[31], px_reg} - {cur_x[31], cur_x};
    assign dv     = {py_reg[31], py_reg} - {cur_y[31], cur_y};
    assign nid_inc = (nid_reg + 64'd1 == 64'd0) ? 64'd1 : nid_reg + 64'd1;

    // shared multiplier operand select
    logic signed [CW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [BW-1:0] cos_v, sin_v;
    logic                 is_dist, neg;

    assign cos_v   = cx[BW-1:0];
    assign sin_v   = cy[BW-1:0];
    assign is_dist = (mode_reg == mfopt_pkg::MODE_DIST);
    assign neg     = (mode_reg == mfopt_pkg::MODE_ADD_REL);

    always_comb begin
        if (is_dist) begin
            mul_a = cx;
            mul_b = mfopt_pkg::KINV_Q28;
        end else begin
            case (cnt_reg)
                3'd0:    begin mul_a = CW'(u_reg); mul_b = cos_v; end
                3'd1:    begin mul_a = CW'(v_reg); mul_b = sin_v; end
                3'd2:    begin mul_a = CW'(v_reg); mul_b = cos_v; end
                default: begin mul_a = CW'(u_reg); mul_b = sin_v; end
            endcase
        end
    end

    logic signed [31:0] r1, r2;
    assign r1 = mfopt_pkg::rnd30_sat(s1_reg);
    assign r2 = mfopt_pkg::rnd30_sat(s2_reg);

    assign s_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        ids_next   = ids_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        hd_next    = hd_reg;
        nid_next   = nid_reg;
        mode_next  = mode_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        ang_next   = ang_reg;
        qid_next   = qid_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        rst_next   = rst_reg;
        rnid_next  = rnid_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rth_next   = rth_reg;
        rd_next    = rd_reg;
        mv_next    = mv_reg;
        ost_next   = ost_reg;
        onid_next  = onid_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oth_next   = oth_reg;
        od_next    = od_reg;
        creq       = '0;
        cang       = cur_hd;
        cvx        = CW'(du);
        cvy        = CW'(dv);

        // output beat taken
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = mfopt_pkg::mode_t'(s_mode);
                    px_next    = s_dx_or_x;
                    py_next    = s_dy_or_y;
                    ang_next   = s_angle;
                    qid_next   = s_frame_id;
                    idx_next   = '0;
                    rst_next   = mfopt_pkg::ST_OK;
                    rnid_next  = '0;
                    rx_next    = '0;
                    ry_next    = '0;
                    rth_next   = '0;
                    rd_next    = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN: begin
                if (!is_upd && !is_add && qid_reg == 64'd0) begin
                    rst_next   = mfopt_pkg::ST_ZERO_ID;
                    state_next = S_DONE;
                end else if (hit) begin
                    case (mode_reg)
                        mfopt_pkg::MODE_UPD_REL, mfopt_pkg::MODE_UPD_ABS: begin
                            u_next     = {px_reg[31], px_reg};
                            v_next     = {py_reg[31], py_reg};
                            creq.start = 1'b1;
                            state_next = S_CORD;
                        end
                        mfopt_pkg::MODE_ADD_ABS: begin
                            ids_next[idx_reg] = nid_reg;
                            fx_next[idx_reg]  = px_reg;
                            fy_next[idx_reg]  = py_reg;
                            hd_next[idx_reg]  = ang_reg;
                            rnid_next  = nid_reg;
                            nid_next   = nid_inc;
                            state_next = S_DONE;
                        end
                        mfopt_pkg::MODE_ADD_REL: begin
                            u_next     = {px_reg[31], px_reg};
                            v_next     = {py_reg[31], py_reg};
                            cang       = ang_reg;
                            creq.start = 1'b1;
                            state_next = S_CORD;
                        end
                        mfopt_pkg::MODE_DELETE: begin
                            ids_next[idx_reg] = '0;
                            fx_next[idx_reg]  = '0;
                            fy_next[idx_reg]  = '0;
                            hd_next[idx_reg]  = '0;
                            state_next = S_DONE;
                        end
                        mfopt_pkg::MODE_GET_POS: begin
                            rx_next    = cur_x;
                            ry_next    = cur_y;
                            rth_next   = cur_hd;
                            state_next = S_DONE;
                        end
                        mfopt_pkg::MODE_XFORM: begin
                            u_next     = du;
                            v_next     = dv;
                            rth_next   = ang_reg - cur_hd;
                            creq.start = 1'b1;
                            state_next = S_CORD;
                        end
                        default: begin
                            // distance: vectoring on the offset
                            creq.start = 1'b1;
                            creq.vec   = 1'b1;
                            state_next = S_CORD;
                        end
                    endcase
                end else if (last) begin
                    if (is_upd) begin
                        rst_next = mfopt_pkg::ST_OK;
                    end else if (is_add) begin
                        rst_next = mfopt_pkg::ST_FULL;
                    end else begin
                        rst_next = mfopt_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end else begin
                    idx_next = IW'(idx_reg + 1'b1);
                end
            end

            S_CORD: begin
                if (cdone) begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end

            // one product per cycle, accumulated in the next cycle
            S_MUL: begin
                prod_next = mul_a * mul_b;
                cnt_next  = cnt_reg + 3'd1;
                if (is_dist) begin
                    if (cnt_reg == 3'd1) begin
                        s1_next    = prod_reg;
                        state_next = S_RND;
                    end
                end else begin
                    case (cnt_reg)
                        3'd1:    acc_next = neg ? -prod_reg : prod_reg;
                        3'd2:    s1_next  = acc_reg + prod_reg;
                        3'd3:    acc_next = prod_reg;
                        3'd4: begin
                            s2_next    = neg ? acc_reg + prod_reg : acc_reg - prod_reg;
                            state_next = S_RND;
                        end
                        default: ;
                    endcase
                end
            end

            S_RND: begin
                case (mode_reg)
                    mfopt_pkg::MODE_ADD_REL: begin
                        ids_next[idx_reg] = nid_reg;
                        fx_next[idx_reg]  = r1;
                        fy_next[idx_reg]  = r2;
                        hd_next[idx_reg]  = -ang_reg;
                        rnid_next  = nid_reg;
                        nid_next   = nid_inc;
                        state_next = S_DONE;
                    end
                    mfopt_pkg::MODE_XFORM: begin
                        rx_next    = r1;
                        ry_next    = r2;
                        state_next = S_DONE;
                    end
                    mfopt_pkg::MODE_DIST: begin
                        rd_next    = mfopt_pkg::rnd28_dist(s1_reg);
                        state_next = S_DONE;
                    end
                    default: begin
                        gx_next    = r1;
                        gy_next    = r2;
                        state_next = S_APPLY;
                    end
                endcase
            end

            // update: move frame and turn heading
            S_APPLY: begin
                fx_next[idx_reg] = mfopt_pkg::add_sat(cur_x, gx_reg);
                fy_next[idx_reg] = mfopt_pkg::add_sat(cur_y, gy_reg);
                hd_next[idx_reg] = (mode_reg == mfopt_pkg::MODE_UPD_REL) ?
                                   cur_hd + ang_reg : ang_reg;
                if (last) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = IW'(idx_reg + 1'b1);
                    state_next = S_SCAN;
                end
            end

            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ost_next   = rst_reg;
                    onid_next  = rnid_reg;
                    ox_next    = rx_reg;
                    oy_next    = ry_reg;
                    oth_next   = rth_reg;
                    od_next    = rd_reg;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            nid_reg   <= 64'd1;
            for (int i = 0; i < NF; i++) begin
                ids_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            nid_reg   <= nid_next;
            ids_reg   <= ids_next;
        end
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        hd_reg    <= hd_next;
        mode_reg  <= mode_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        ang_reg   <= ang_next;
        qid_reg   <= qid_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        rst_reg   <= rst_next;
        rnid_reg  <= rnid_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        rth_reg   <= rth_next;
        rd_reg    <= rd_next;
        ost_reg   <= ost_next;
        onid_reg  <= onid_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oth_reg   <= oth_next;
        od_reg    <= od_next;
    end

    assign m_valid     = mv_reg;
    assign m_status    = ost_reg;
    assign m_new_id    = onid_reg;
    assign m_out_x     = ox_reg;
    assign m_out_y     = oy_reg;
    assign m_out_theta = oth_reg;
    assign m_distance  = od_reg;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        new_id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] theta;
    logic [30:0]        mag;
} pose_result_t;

class pose_table_scoreboard;
    localparam int NSLOT = mfopt_pkg::MAX_FRAMES;
    localparam int NSTEP = mfopt_pkg::CORDIC_STEPS;
    localparam longint KQ30 = 652032875;
    localparam longint KQ28 = 163008219;
    localparam longint HALF_PI = 64'sd1073741824;
    localparam longint FULL_PI = 64'sd2147483648;

    longint atan_tab[NSTEP] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517D};

    logic [63:0]        slot_id[NSLOT];
    longint             slot_x[NSLOT];
    longint             slot_y[NSLOT];
    logic signed [15:0] slot_hd[NSLOT];
    logic [63:0]        next_id;
    pose_result_t       pending[$];
    int                 errors;

    function new();
        foreach (slot_id[i]) begin
            slot_id[i] = '0;
            slot_x[i]  = 0;
            slot_y[i]  = 0;
            slot_hd[i] = '0;
        end
        next_id = 64'd1;
        errors  = 0;
    endfunction

    static function longint clip32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sd2147483647;
        if (v < -128'sd2147483648) return -64'sd2147483648;
        return longint'(v);
    endfunction

    static function longint round30(logic signed [127:0] v);
        return clip32((v + 128'sd536870912) >>> 30);
    endfunction

    // rotation-mode CORDIC, Q2.30 cos/sin, folded outside +-pi/2
    function void sin_cos(input logic signed [15:0] a, output longint c, output longint s);
        longint z, x, y, sx, sy;
        bit flip;
        z = longint'(a) * 65536;
        x = KQ30;
        y = 0;
        flip = 0;
        if (z > HALF_PI) begin
            z -= FULL_PI; flip = 1;
        end else if (z < -HALF_PI) begin
            z += FULL_PI; flip = 1;
        end
        for (int i = 0; i < NSTEP; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (z >= 0) begin
                x -= sy; y += sx; z -= atan_tab[i];
            end else begin
                x += sy; y -= sx; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // body motion into frame coordinates, saturated
    function void turn(input longint dx, input longint dy, input logic signed [15:0] hd,
                       output longint gx, output longint gy);
        longint c, s;
        logic signed [127:0] wdx, wdy, wc, ws;
        sin_cos(hd, c, s);
        wdx = dx; wdy = dy; wc = c; ws = s;
        gx = round30(wdx * wc + wdy * ws);
        gy = round30(wdy * wc - wdx * ws);
    endfunction

    // vectoring CORDIC magnitude, scaled by 1/K and clamped
    function longint range_to(input longint dx, input longint dy);
        longint x, y, sx, sy;
        logic signed [127:0] v;
        x = dx < 0 ? -dx : dx;
        y = dy;
        for (int i = 0; i < NSTEP; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (y > 0) begin
                x += sy; y -= sx;
            end else begin
                x -= sy; y += sx;
            end
        end
        v = x;
        v = (v * 128'sd163008219 + 128'sd134217728) >>> 28;
        if (v < 0) return 0;
        if (v > 128'sd2147483647) return 64'sd2147483647;
        return longint'(v);
    endfunction

    function int find_slot(logic [63:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (slot_id[i] == id) return i;
        return -1;
    endfunction

    function logic [63:0] pick_live();
        logic [63:0] ids[$];
        foreach (slot_id[i])
            if (slot_id[i] != 0) ids.push_back(slot_id[i]);
        if (ids.size() == 0) return 64'd0;
        return ids[$urandom_range(ids.size() - 1)];
    endfunction

    // accepted input beat: advance the table and queue the result it produces
    function void note_beat(logic [2:0] mode, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] ang, logic [63:0] id);
        pose_result_t r;
        longint gx, gy, c, s, dx, dy;
        logic signed [127:0] wx, wy, wc, ws;
        int k;
        r = '{mfopt_pkg::ST_OK, 64'd0, 32'sd0, 32'sd0, 16'sd0, 31'd0};
        if (mode == mfopt_pkg::MODE_UPD_REL || mode == mfopt_pkg::MODE_UPD_ABS) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (slot_id[i] == 0) continue;
                turn(px, py, slot_hd[i], gx, gy);
                slot_x[i] = clip32(slot_x[i] + gx);
                slot_y[i] = clip32(slot_y[i] + gy);
                slot_hd[i] = (mode == mfopt_pkg::MODE_UPD_REL) ? slot_hd[i] + ang : ang;
            end
        end else if (mode == mfopt_pkg::MODE_ADD_ABS || mode == mfopt_pkg::MODE_ADD_REL) begin
            k = find_slot(64'd0);
            if (k < 0) begin
                r.status = mfopt_pkg::ST_FULL;
            end else begin
                r.new_id = next_id;
                next_id++;
                if (next_id == 0) next_id = 64'd1;
                slot_id[k] = r.new_id;
                if (mode == mfopt_pkg::MODE_ADD_ABS) begin
                    slot_x[k] = longint'(px); slot_y[k] = longint'(py); slot_hd[k] = ang;
                end else begin
                    sin_cos(ang, c, s);
                    wx = px; wy = py; wc = c; ws = s;
                    slot_x[k]  = round30(wy * ws - wx * wc);
                    slot_y[k]  = round30(wx * ws + wy * wc);
                    slot_hd[k] = -ang;
                end
            end
        end else if (id == 0) begin
            r.status = mfopt_pkg::ST_ZERO_ID;
        end else begin
            k = find_slot(id);
            if (k < 0) begin
                r.status = mfopt_pkg::ST_NOT_FOUND;
            end else if (mode == mfopt_pkg::MODE_DELETE) begin
                slot_id[k] = '0; slot_x[k] = 0; slot_y[k] = 0; slot_hd[k] = '0;
            end else if (mode == mfopt_pkg::MODE_GET_POS) begin
                r.x = 32'(slot_x[k]); r.y = 32'(slot_y[k]); r.theta = slot_hd[k];
            end else begin
                dx = longint'(px) - slot_x[k];
                dy = longint'(py) - slot_y[k];
                if (mode == mfopt_pkg::MODE_XFORM) begin
                    turn(dx, dy, slot_hd[k], gx, gy);
                    r.x = 32'(gx); r.y = 32'(gy); r.theta = ang - slot_hd[k];
                end else begin
                    r.mag = 31'(range_to(dx, dy));
                end
            end
        end
        pending.push_back(r);
    endfunction

    function void check_beat(pose_result_t got);
        pose_result_t exp;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: status %0d", got.status);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: exp st=%0d id=%h x=%h y=%h th=%h d=%h",
                          " | got st=%0d id=%h x=%h y=%h th=%h d=%h"},
                         exp.status, exp.new_id, exp.x, exp.y, exp.theta, exp.mag,
                         got.status, got.new_id, got.x, got.y, got.theta, got.mag);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_mode;
    logic signed [31:0] s_dx_or_x;
    logic signed [31:0] s_dy_or_y;
    logic signed [15:0] s_angle;
    logic [63:0]        s_frame_id;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [63:0]        m_new_id;
    logic signed [31:0] m_out_x;
    logic signed [31:0] m_out_y;
    logic signed [15:0] m_out_theta;
    logic [30:0]        m_distance;

    pose_table_scoreboard pose_sb;
    int  send_idle, recv_idle;
    int  hold_req  = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  cycle_cnt = 0;

    multi_frame_odometry_pose_table DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random ready, long hold-off on request, check each beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pose_sb.check_beat('{m_status, m_new_id, m_out_x, m_out_y, m_out_theta,
                                 m_distance});
        if (hold_req != hold_seen && hold_left == 0) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(logic [2:0] mode, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [15:0] a, logic [63:0] id);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_dx_or_x  <= x;
        s_dy_or_y  <= y;
        s_angle    <= a;
        s_frame_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pose_sb.note_beat(mode, x, y, a, id);
    endtask

    // coordinates: mostly moderate, sometimes full range or extremes
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    function automatic logic [63:0] rand_id();
        return {$urandom, $urandom};
    endfunction

    task automatic random_beat();
        logic [63:0] id;
        int pick;
        pick = $urandom_range(99);
        id = pose_sb.pick_live();
        if (pick < 20) begin
            send_beat($urandom_range(1) ? mfopt_pkg::MODE_ADD_ABS : mfopt_pkg::MODE_ADD_REL,
                      rand_coord(), rand_coord(), 16'($urandom), 64'd0);
        end else if (pick < 42) begin
            send_beat($urandom_range(3) == 0 ? mfopt_pkg::MODE_UPD_ABS : mfopt_pkg::MODE_UPD_REL,
                      rand_coord() >>> $urandom_range(12), rand_coord() >>> $urandom_range(12),
                      16'($urandom), rand_id());
        end else if (pick < 52) begin
            send_beat(mfopt_pkg::MODE_DELETE, rand_coord(), rand_coord(), 16'($urandom), id);
        end else if (pick < 85) begin
            send_beat(3'(mfopt_pkg::MODE_GET_POS + $urandom_range(2)), rand_coord(),
                      rand_coord(), 16'($urandom), id);
        end else begin
            // noise: any mode, random or zero id
            send_beat(3'($urandom), $urandom, $urandom, 16'($urandom),
                      $urandom_range(3) == 0 ? 64'd0 : rand_id());
        end
    endtask

    initial begin
        pose_sb    = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_mode     = mfopt_pkg::MODE_GET_POS;
        s_dx_or_x  = '0;
        s_dy_or_y  = '0;
        s_angle    = '0;
        s_frame_id = '0;
        send_idle  = 36;
        recv_idle  = 74;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty update, extreme poses, table full, bad ids, saturation
        send_beat(mfopt_pkg::MODE_UPD_REL, 32'sh00010000, 32'sh00020000, 16'sh1000, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_ABS, 32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_ABS, 32'sh80000000, 32'sh7FFFFFFF, 16'sh8000, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_REL, 32'sh00030000, -32'sh00010000, 16'sh4000, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_REL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh8000, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_REL, 32'sh80000000, 32'sh80000000, 16'sh2000, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_ABS, 32'sh0, 32'sh0, 16'sh0, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_ABS, 32'sh00100000, 32'sh00200000, -16'sh4000, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_ABS, -32'sh00100000, 32'sh00050000, 16'sh0001, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_ABS, 32'sh1, 32'sh1, 16'sh1, 64'd0);
        send_beat(mfopt_pkg::MODE_GET_POS, 32'sh0, 32'sh0, 16'sh0, 64'd1);
        send_beat(mfopt_pkg::MODE_XFORM, 32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 64'd2);
        send_beat(mfopt_pkg::MODE_DIST, 32'sh80000000, 32'sh7FFFFFFF, 16'sh0, 64'd1);
        send_beat(mfopt_pkg::MODE_DIST, 32'sh00010000, 32'sh00010000, 16'sh0, 64'd7);
        send_beat(mfopt_pkg::MODE_DIST, 32'sh0, 32'sh0, 16'sh0, 64'd0);
        send_beat(mfopt_pkg::MODE_GET_POS, 32'sh0, 32'sh0, 16'sh0, 64'hFFFFFFFFFFFFFFFF);
        send_beat(mfopt_pkg::MODE_UPD_REL, 32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 64'd0);
        send_beat(mfopt_pkg::MODE_UPD_ABS, -32'sh00080000, 32'sh00040000, -16'sh8000, 64'd0);
        send_beat(mfopt_pkg::MODE_DELETE, 32'sh0, 32'sh0, 16'sh0, 64'd3);
        send_beat(mfopt_pkg::MODE_DELETE, 32'sh0, 32'sh0, 16'sh0, 64'd3);
        send_beat(mfopt_pkg::MODE_XFORM, 32'sh00010000, 32'sh0, 16'sh1234, 64'd0);
        send_beat(mfopt_pkg::MODE_ADD_REL, 32'sh0, 32'sh00010000, -16'sh8000, 64'd0);

        // random phases: receiver-heavy idle, sender-heavy idle, no idle
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 74 : 0;
            recv_idle = (phase == 0) ? 74 : (phase == 1) ? 36 : 0;
            if (phase == 2) hold_req++;
            for (int n = 0; n < 330; n++) begin
                if (phase == 0 && n == 100) hold_req++;
                random_beat();
            end
        end
        s_valid <= 1'b0;

        while (pose_sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (pose_sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/mfopt_pkg.sv
hw/rtl/mfopt_cordic.sv
hw/rtl/multi_frame_odometry_pose_table.sv
dv/tb_top.sv
